@@ sv/numeric_literal_parser_defines.svh @@
// ----------------------------------------------------------------------------
// numeric_literal_parser_defines.svh
// Assertion macros shared by the literal parser modules.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_DEFINES_SVH
`define NUMERIC_LITERAL_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define NLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define NLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NLP_ASSERT(lbl, prop, msg)
`define NLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/nlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_pkg
// Types and constants of the integer literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

  typedef enum logic [2:0] {
    K_BYTE    = 3'd0,
    K_INT     = 3'd1,
    K_UINT    = 3'd2,
    K_LONG    = 3'd3,
    K_ULONG   = 3'd4,
    K_LONG64  = 3'd5,
    K_ULONG64 = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_HEX_DIGITS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_RADIX   = 2'd0,
    REG_KIND    = 2'd1,
    REG_PROMOTE = 2'd2
  } reg_idx_e;

  localparam logic [4:0]  RADIX_DEC       = 5'd10;
  localparam logic [4:0]  RADIX_HEX       = 5'd16;
  localparam logic [4:0]  CNT_MAX         = 5'd31;
  localparam logic [4:0]  HEX_INT_DIGITS  = 5'd4;
  localparam logic [4:0]  HEX_LONG_DIGITS = 5'd8;
  localparam logic [4:0]  LONG64_DIGITS   = 5'd16;

  localparam logic [63:0] BYTE_MAX  = 64'd255;
  localparam logic [63:0] INT_MAX   = 64'd32767;
  localparam logic [63:0] UINT_MAX  = 64'd65535;
  localparam logic [63:0] LONG_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] ULONG_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES  = '1;

  // configuration register contents
  typedef struct packed {
    logic [4:0] radix;
    logic [2:0] target_kind;
    logic       promote;
  } cfg_t;

  // accumulator state frozen at the last character of a literal
  typedef struct packed {
    logic [63:0] acc;
    logic [4:0]  cnt;
    logic        ovf;
  } snap_t;

  // one result item
  typedef struct packed {
    logic [63:0] value;
    kind_e       kind;
    status_e     status;
  } res_t;

endpackage

@@ sv/nlp_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_accum
// Input register and per-character multiply-add; freezes the state on the
// last character of a literal.
// ----------------------------------------------------------------------------
`include "numeric_literal_parser_defines.svh"

module nlp_accum import nlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] digit_char_i,
  input  logic       last_char_i,
  output logic       snap_valid_o,
  output snap_t      snap_o,
  input  logic       snap_ready_i
);

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") v = c - 8'(48);
    else if (c >= "a" && c <= "f") v = c - 8'(87);
    else v = c - 8'(55);
    return v;
  endfunction

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic [63:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic        snap_valid_q, snap_valid_d;
  snap_t       snap_q;
  logic        snap_free;
  logic        consume;
  logic        in_ready;
  logic [68:0] sum;

  assign snap_free  = !snap_valid_q || snap_ready_i;
  assign consume    = in_valid_q && (!last_q || snap_free);
  assign in_ready   = !in_valid_q || consume;
  assign in_stall_o = !in_ready;

  // full-width product: any bit above 63 means the true value reached 2^64
  assign sum = ({5'd0, acc_q} * {64'd0, cfg_i.radix}) + {61'd0, digit_value(char_q)};

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (consume) begin
      if (last_q) begin
        acc_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = sum[63:0];
        cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 5'd1;
        ovf_d = ovf_q || (|sum[68:64]);
      end
    end
    snap_valid_d = snap_free ? (consume && last_q) : snap_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      acc_q        <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      if (in_ready) in_valid_q <= in_valid_i;
      acc_q        <= acc_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      char_q <= digit_char_i;
      last_q <= last_char_i;
    end
    if (snap_free && consume && last_q) begin
      snap_q.acc <= sum[63:0];
      snap_q.cnt <= (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 5'd1;
      snap_q.ovf <= ovf_q || (|sum[68:64]);
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  `NLP_ASSERT_NEXT(a_clear_after_last, consume && last_q, acc_q == '0 && cnt_q == '0 && !ovf_q, "state not cleared after last character")
  `NLP_ASSERT_NEXT(a_snap_held, snap_valid_q && !snap_ready_i, snap_valid_q && $stable(snap_q), "held snapshot changed")
  `NLP_ASSERT_NEXT(a_ovf_sticky, ovf_q && consume && !last_q, ovf_q, "overflow flag dropped mid literal")

endmodule

@@ sv/nlp_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_finish
// Range checks, kind promotion and result register.
// ----------------------------------------------------------------------------
`include "numeric_literal_parser_defines.svh"

module nlp_finish import nlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        snap_valid_i,
  input  snap_t       snap_i,
  output logic        snap_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_bits_o,
  output logic [2:0]  result_kind_o,
  output logic [1:0]  status_o
);

  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        out_ready;
  kind_e       tk;
  logic        too_big;
  logic [63:0] acc;
  logic [63:0] mag;

  assign out_ready    = !out_valid_q || !out_stall_i;
  assign snap_ready_o = out_ready;

  always_comb begin
    tk      = kind_e'(cfg_i.target_kind);
    acc     = snap_i.acc;
    too_big = snap_i.ovf || (cfg_i.radix != RADIX_DEC && snap_i.cnt > LONG64_DIGITS);
    mag     = acc[63] ? (64'd0 - acc) : acc;
    res_d.value  = '0;
    res_d.kind   = tk;
    res_d.status = ST_OK;
    if (cfg_i.promote && (tk == K_INT || tk == K_LONG)) begin
      if (too_big) begin
        res_d.value  = ALL_ONES;
        res_d.kind   = K_LONG64;
        res_d.status = ST_OVERFLOW;
      end else begin
        res_d.value = acc;
        if (tk == K_INT && mag <= INT_MAX) res_d.kind = K_INT;
        else if (mag <= LONG_MAX) res_d.kind = K_LONG;
        else res_d.kind = K_LONG64;
      end
    end else if (cfg_i.promote && (tk == K_UINT || tk == K_ULONG)) begin
      if (too_big) begin
        res_d.value  = ALL_ONES;
        res_d.kind   = K_ULONG64;
        res_d.status = ST_OVERFLOW;
      end else begin
        res_d.value = acc;
        if (tk == K_UINT && acc <= UINT_MAX) res_d.kind = K_UINT;
        else if (acc <= ULONG_MAX) res_d.kind = K_ULONG;
        else res_d.kind = K_ULONG64;
      end
    end else begin
      case (tk)
        K_BYTE: begin
          if (snap_i.ovf || acc > BYTE_MAX) res_d.status = ST_OVERFLOW;
          else res_d.value = acc;
        end
        K_INT: begin
          if (cfg_i.radix == RADIX_HEX && snap_i.cnt > HEX_INT_DIGITS)
            res_d.status = ST_HEX_DIGITS;
          else if (snap_i.ovf || acc > ((cfg_i.radix == RADIX_DEC) ? INT_MAX : UINT_MAX))
            res_d.status = ST_OVERFLOW;
          else res_d.value = {{48{acc[15]}}, acc[15:0]};
        end
        K_UINT: begin
          if (snap_i.ovf || acc > UINT_MAX) res_d.status = ST_OVERFLOW;
          else res_d.value = acc;
        end
        K_LONG, K_ULONG: begin
          if (cfg_i.radix == RADIX_HEX) begin
            if (snap_i.cnt > HEX_LONG_DIGITS) res_d.status = ST_HEX_DIGITS;
            else if (tk == K_LONG) res_d.value = {{32{acc[31]}}, acc[31:0]};
            else res_d.value = {32'd0, acc[31:0]};
          end else if (too_big || acc > ((tk == K_LONG) ? LONG_MAX : ULONG_MAX)) begin
            res_d.status = ST_OVERFLOW;
          end else begin
            res_d.value = acc;
          end
        end
        default: begin
          // long64, ulong64 and the unused code, which acts as ulong64
          res_d.kind = (tk == K_LONG64) ? K_LONG64 : K_ULONG64;
          if (too_big) begin
            res_d.value  = ALL_ONES;
            res_d.status = ST_OVERFLOW;
          end else begin
            res_d.value = acc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && snap_valid_i) res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_bits_o  = res_q.value;
  assign result_kind_o = res_q.kind;
  assign status_o      = res_q.status;

  `NLP_ASSERT(a_wide_ovf_ones, out_valid_q && res_q.status == ST_OVERFLOW && (res_q.kind == K_LONG64 || res_q.kind == K_ULONG64) |-> res_q.value == ALL_ONES, "64-bit overflow not all ones")
  `NLP_ASSERT(a_err_zero, out_valid_q && res_q.status != ST_OK && res_q.kind != K_LONG64 && res_q.kind != K_ULONG64 |-> res_q.value == '0, "error result carries a value")

endmodule

@@ sv/numeric_literal_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_parser
// Integer literal conversion, one ASCII digit per transfer, with range checks
// against a configured target kind and optional promotion by magnitude.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                payload
//   input     in         in_valid_i / in_stall_o  digit_char_i, last_char_i
//   result    out        out_valid_o/out_stall_i  value_bits_o, result_kind_o,
//                                                 status_o
//   config    in         APB (psel/penable/...)   radix, target_kind, promote
//
// One character per cycle while in_stall_o is low; the accumulator loop is a
// single 64x5 multiply-add, so a character follows the previous one directly.
// A result reaches out_valid_o through the input register, the state
// snapshot and the result register after the last character's transfer.
// Reset clears the accumulator, handshake state and configuration
// (radix 10, target int, no promotion); no clearing pass is needed.
// A stalled result holds; in_stall_o rises only while a last character waits
// in the input register, the snapshot and result registers are both full
// and out_stall_i is high.
//
// Register map (32-bit, byte addresses):
//   0x0 radix [4:0]   0x4 target_kind [2:0]   0x8 promote [0]
// ----------------------------------------------------------------------------

module numeric_literal_parser import nlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  digit_char_i,
  input  logic        last_char_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_bits_o,
  output logic [2:0]  result_kind_o,
  output logic [1:0]  status_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     snap_valid;
  snap_t    snap;
  logic     snap_ready;

  // --- configuration registers -------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix       <= RADIX_DEC;
      cfg_q.target_kind <= K_INT;
      cfg_q.promote     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RADIX:   cfg_q.radix       <= pwdata[4:0];
        REG_KIND:    cfg_q.target_kind <= pwdata[2:0];
        REG_PROMOTE: cfg_q.promote     <= pwdata[0];
        default:     ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIX:   prdata = {27'd0, cfg_q.radix};
      REG_KIND:    prdata = {29'd0, cfg_q.target_kind};
      REG_PROMOTE: prdata = {31'd0, cfg_q.promote};
      default:     prdata = '0;
    endcase
  end

  // --- accumulate: input register, multiply-add, snapshot on last ---------
  nlp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .digit_char_i (digit_char_i),
    .last_char_i  (last_char_i),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  // --- finish: range checks and promotion into the result register --------
  nlp_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .snap_valid_i  (snap_valid),
    .snap_i        (snap),
    .snap_ready_o  (snap_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_bits_o  (value_bits_o),
    .result_kind_o (result_kind_o),
    .status_o      (status_o)
  );

endmodule
